// ===== rtl/core/adll_pkg.sv =====
// Types and constants shared by the array doubly linked list unit.
`default_nettype none
package adll_pkg;

  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_DELETE     = 3'd2;
  localparam logic [2:0] CMD_INS_BEFORE = 3'd3;
  localparam logic [2:0] CMD_INS_AFTER  = 3'd4;
  localparam logic [2:0] CMD_READ       = 3'd5;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_DEAD = 2'd2;

  typedef struct packed {
    logic [2:0]              cmd;
    logic [IDX_W-1:0]        entry_index;
    logic signed [DATA_W-1:0] new_value;
  } adll_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [IDX_W-1:0]         assigned_index;
    logic [IDX_W-1:0]         head_index;
    logic [IDX_W-1:0]         tail_index;
    logic                     list_empty;
    logic signed [DATA_W-1:0] entry_value;
    logic [IDX_W-1:0]         entry_prev;
    logic [IDX_W-1:0]         entry_next;
  } adll_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_DONE
  } adll_state_t;

  typedef struct packed {
    logic val_we;
    logic live_we;
    logic live_data;
    logic prev_we;
    logic next_we;
  } adll_wr_t;

endpackage
`default_nettype wire

// ===== rtl/core/adll_store.sv =====
// Entry memories: value, prev link, next link and live bit, with registered read outputs.
`default_nettype none
module adll_store #(
  parameter int POOL_DEPTH  = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                            clk,
  input  wire                            rd_en,
  input  wire [$clog2(POOL_DEPTH)-1:0]   rd_addr,
  input  adll_pkg::adll_wr_t             wr,
  input  wire [$clog2(POOL_DEPTH)-1:0]   ent_waddr,
  input  wire [VALUE_WIDTH-1:0]          val_wdata,
  input  wire [$clog2(POOL_DEPTH)-1:0]   prev_waddr,
  input  wire [$clog2(POOL_DEPTH)-1:0]   prev_wdata,
  input  wire [$clog2(POOL_DEPTH)-1:0]   next_waddr,
  input  wire [$clog2(POOL_DEPTH)-1:0]   next_wdata,
  output logic [VALUE_WIDTH-1:0]         rd_value,
  output logic [$clog2(POOL_DEPTH)-1:0]  rd_prev,
  output logic [$clog2(POOL_DEPTH)-1:0]  rd_next,
  output logic                           rd_live
);
  import adll_pkg::*;

  localparam int IW = $clog2(POOL_DEPTH);

  logic [VALUE_WIDTH-1:0] val_mem  [POOL_DEPTH];
  logic [IW-1:0]          prev_mem [POOL_DEPTH];
  logic [IW-1:0]          next_mem [POOL_DEPTH];
  logic                   live_mem [POOL_DEPTH];

  logic [VALUE_WIDTH-1:0] rd_value_r;
  logic [IW-1:0]          rd_prev_r;
  logic [IW-1:0]          rd_next_r;
  logic                   rd_live_r;

  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      val_mem[ent_waddr] <= val_wdata;
    end
    if (wr.live_we) begin
      live_mem[ent_waddr] <= wr.live_data;
    end
    if (wr.prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (wr.next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_value_r <= val_mem[rd_addr];
      rd_prev_r  <= prev_mem[rd_addr];
      rd_next_r  <= next_mem[rd_addr];
      rd_live_r  <= live_mem[rd_addr];
    end
  end

  assign rd_value = rd_value_r;
  assign rd_prev  = rd_prev_r;
  assign rd_next  = rd_next_r;
  assign rd_live  = rd_live_r;

endmodule
`default_nettype wire

// ===== rtl/core/adll_ctrl.sv =====
// Command sequencer: live check, link updates, head/tail state and result register.
`default_nettype none
module adll_ctrl #(
  parameter int POOL_DEPTH  = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  adll_pkg::adll_in_t             in_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output adll_pkg::adll_out_t            out_data,
  output logic                           rd_en,
  output logic [$clog2(POOL_DEPTH)-1:0]  rd_addr,
  output adll_pkg::adll_wr_t             wr,
  output logic [$clog2(POOL_DEPTH)-1:0]  ent_waddr,
  output logic [VALUE_WIDTH-1:0]         val_wdata,
  output logic [$clog2(POOL_DEPTH)-1:0]  prev_waddr,
  output logic [$clog2(POOL_DEPTH)-1:0]  prev_wdata,
  output logic [$clog2(POOL_DEPTH)-1:0]  next_waddr,
  output logic [$clog2(POOL_DEPTH)-1:0]  next_wdata,
  input  wire [VALUE_WIDTH-1:0]          rd_value,
  input  wire [$clog2(POOL_DEPTH)-1:0]   rd_prev,
  input  wire [$clog2(POOL_DEPTH)-1:0]   rd_next,
  input  wire                            rd_live
);
  import adll_pkg::*;

  localparam int IW = $clog2(POOL_DEPTH);
  localparam int FW = IW + 1;
  localparam int CW = (FW > IDX_W) ? FW : IDX_W;

  adll_state_t            state_r, state_nxt;
  logic [2:0]             cmd_r, cmd_nxt;
  logic [IDX_W-1:0]       k_r, k_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic [IW-1:0]          head_r, head_nxt;
  logic [IW-1:0]          tail_r, tail_nxt;
  logic                   empty_r, empty_nxt;
  logic [FW-1:0]          next_free_r, next_free_nxt;
  logic [IW-1:0]          n_r, n_nxt;
  logic [IW-1:0]          lnk_next_addr_r, lnk_next_addr_nxt;
  logic [IW-1:0]          lnk_prev_addr_r, lnk_prev_addr_nxt;
  logic                   need_link;
  adll_out_t              res_r, res_nxt;
  adll_out_t              out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [IW-1:0]          k_addr;
  logic [IW-1:0]          n_new;
  logic                   full;
  logic                   live_ok;
  logic                   out_free;

  assign k_addr   = IW'(k_r);
  assign n_new    = next_free_r[IW-1:0];
  assign full     = (next_free_r == FW'(POOL_DEPTH));
  assign live_ok  = (k_r != '0) && (CW'(k_r) < CW'(next_free_r)) && rd_live;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = need_link ? S_LINK : S_DONE;
      end
      S_LINK: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_nxt           = cmd_r;
    k_nxt             = k_r;
    val_nxt           = val_r;
    head_nxt          = head_r;
    tail_nxt          = tail_r;
    empty_nxt         = empty_r;
    next_free_nxt     = next_free_r;
    n_nxt             = n_r;
    lnk_next_addr_nxt = lnk_next_addr_r;
    lnk_prev_addr_nxt = lnk_prev_addr_r;
    need_link         = 1'b0;
    res_nxt           = res_r;
    out_nxt           = out_r;
    out_valid_nxt     = out_valid_r && out_stall;
    rd_en             = 1'b0;
    wr                = '0;
    ent_waddr         = n_new;
    val_wdata         = val_r;
    prev_waddr        = n_new;
    prev_wdata        = n_new;
    next_waddr        = n_new;
    next_wdata        = n_new;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rd_en   = 1'b1;
          cmd_nxt = in_data.cmd;
          k_nxt   = in_data.entry_index;
          val_nxt = VALUE_WIDTH'(in_data.new_value);
        end
      end
      S_EXEC: begin
        res_nxt        = '0;
        res_nxt.status = STAT_OK;
        case (cmd_r)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (full) begin
              res_nxt.status = STAT_FULL;
            end else begin
              res_nxt.assigned_index = IDX_W'(n_new);
              n_nxt          = n_new;
              next_free_nxt  = next_free_r + FW'(1);
              wr.val_we      = 1'b1;
              wr.live_we     = 1'b1;
              wr.live_data   = 1'b1;
              wr.prev_we     = 1'b1;
              wr.next_we     = 1'b1;
              if (empty_r) begin
                prev_wdata = n_new;
                next_wdata = n_new;
                head_nxt   = n_new;
                tail_nxt   = n_new;
                empty_nxt  = 1'b0;
              end else begin
                prev_wdata        = tail_r;
                next_wdata        = head_r;
                need_link         = 1'b1;
                lnk_next_addr_nxt = tail_r;
                lnk_prev_addr_nxt = head_r;
                if (cmd_r == CMD_PUSH_FRONT) begin
                  head_nxt = n_new;
                end else begin
                  tail_nxt = n_new;
                end
              end
            end
          end
          CMD_DELETE: begin
            if (!live_ok) begin
              res_nxt.status = STAT_DEAD;
            end else begin
              ent_waddr    = k_addr;
              wr.live_we   = 1'b1;
              wr.live_data = 1'b0;
              if (rd_prev == k_addr && rd_next == k_addr) begin
                head_nxt  = '0;
                tail_nxt  = '0;
                empty_nxt = 1'b1;
              end else begin
                wr.next_we = 1'b1;
                next_waddr = rd_prev;
                next_wdata = rd_next;
                wr.prev_we = 1'b1;
                prev_waddr = rd_next;
                prev_wdata = rd_prev;
                if (head_r == k_addr) begin
                  head_nxt = rd_next;
                end
                if (tail_r == k_addr) begin
                  tail_nxt = rd_prev;
                end
              end
            end
          end
          CMD_INS_BEFORE, CMD_INS_AFTER: begin
            if (!live_ok) begin
              res_nxt.status = STAT_DEAD;
            end else if (full) begin
              res_nxt.status = STAT_FULL;
            end else begin
              res_nxt.assigned_index = IDX_W'(n_new);
              n_nxt         = n_new;
              next_free_nxt = next_free_r + FW'(1);
              need_link     = 1'b1;
              wr.val_we     = 1'b1;
              wr.live_we    = 1'b1;
              wr.live_data  = 1'b1;
              wr.prev_we    = 1'b1;
              wr.next_we    = 1'b1;
              if (cmd_r == CMD_INS_BEFORE) begin
                prev_wdata        = rd_prev;
                next_wdata        = k_addr;
                lnk_next_addr_nxt = rd_prev;
                lnk_prev_addr_nxt = k_addr;
                if (head_r == k_addr) begin
                  head_nxt = n_new;
                end
              end else begin
                prev_wdata        = k_addr;
                next_wdata        = rd_next;
                lnk_next_addr_nxt = k_addr;
                lnk_prev_addr_nxt = rd_next;
                if (tail_r == k_addr) begin
                  tail_nxt = n_new;
                end
              end
            end
          end
          CMD_READ: begin
            if (!live_ok) begin
              res_nxt.status = STAT_DEAD;
            end else begin
              res_nxt.entry_value = DATA_W'(signed'(rd_value));
              res_nxt.entry_prev  = IDX_W'(rd_prev);
              res_nxt.entry_next  = IDX_W'(rd_next);
            end
          end
          default: begin
          end
        endcase
        res_nxt.head_index = IDX_W'(head_nxt);
        res_nxt.tail_index = IDX_W'(tail_nxt);
        res_nxt.list_empty = empty_nxt;
      end
      S_LINK: begin
        wr.next_we = 1'b1;
        next_waddr = lnk_next_addr_r;
        next_wdata = n_r;
        wr.prev_we = 1'b1;
        prev_waddr = lnk_prev_addr_r;
        prev_wdata = n_r;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      next_free_r <= FW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r           <= cmd_nxt;
    k_r             <= k_nxt;
    val_r           <= val_nxt;
    n_r             <= n_nxt;
    lnk_next_addr_r <= lnk_next_addr_nxt;
    lnk_prev_addr_r <= lnk_prev_addr_nxt;
    res_r           <= res_nxt;
    out_r           <= out_nxt;
  end

  assign rd_addr   = IW'(in_data.entry_index);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/core/array_doubly_linked_list_unit.sv =====
// Top level of the array doubly linked list unit.
// Sequence: the accepting edge starts the entry read, S_EXEC checks and writes, S_LINK does a
// second link write to the neighbor entries for commands that add an entry to a non-empty list,
// and S_DONE registers the result once out_stall allows it. One command in flight at a time.
// Reset: synchronous, active low; list empty, head/tail 0, next free index 1, no clearing pass.
`default_nettype none
module array_doubly_linked_list_unit #(
  parameter int POOL_DEPTH  = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  adll_pkg::adll_in_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output adll_pkg::adll_out_t out_data
);
  import adll_pkg::*;

  localparam int IW = $clog2(POOL_DEPTH);

  logic                   rd_en;
  logic [IW-1:0]          rd_addr;
  adll_wr_t               wr;
  logic [IW-1:0]          ent_waddr;
  logic [VALUE_WIDTH-1:0] val_wdata;
  logic [IW-1:0]          prev_waddr;
  logic [IW-1:0]          prev_wdata;
  logic [IW-1:0]          next_waddr;
  logic [IW-1:0]          next_wdata;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic [IW-1:0]          rd_prev;
  logic [IW-1:0]          rd_next;
  logic                   rd_live;

  adll_ctrl #(
    .POOL_DEPTH  (POOL_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .wr         (wr),
    .ent_waddr  (ent_waddr),
    .val_wdata  (val_wdata),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .rd_value   (rd_value),
    .rd_prev    (rd_prev),
    .rd_next    (rd_next),
    .rd_live    (rd_live)
  );

  adll_store #(
    .POOL_DEPTH  (POOL_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk        (clk),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .wr         (wr),
    .ent_waddr  (ent_waddr),
    .val_wdata  (val_wdata),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .rd_value   (rd_value),
    .rd_prev    (rd_prev),
    .rd_next    (rd_next),
    .rd_live    (rd_live)
  );

endmodule
`default_nettype wire

// ===== rtl/core/adll_checker.sv =====
// Port-level assertions for the array doubly linked list unit, bound to the top level.
`default_nettype none
module adll_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input adll_pkg::adll_in_t  in_data,
  input wire                 out_valid,
  input wire                 out_stall,
  input adll_pkg::adll_out_t out_data
);
  import adll_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new transaction taken while a command is in flight");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.list_empty |-> out_data.head_index == '0 && out_data.tail_index == '0)
    else $error("empty list reports nonzero head or tail");

  a_dead_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_DEAD |->
      out_data.assigned_index == '0 && out_data.entry_value == '0 &&
      out_data.entry_prev == '0 && out_data.entry_next == '0)
    else $error("dead target result carries data");

endmodule

bind array_doubly_linked_list_unit adll_checker u_adll_checker (.*);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the array doubly linked list unit: directed table, then random.
module tb;
  import adll_pkg::*;

  localparam int POOL_ENTRIES = 1024;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANDOM_CMDS = 2000;
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  typedef struct packed {
    adll_in_t  item;
    logic      typed;
    adll_out_t want;
  } script_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  adll_in_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  adll_out_t out_data;

  array_doubly_linked_list_unit #(
    .POOL_DEPTH (POOL_ENTRIES),
    .VALUE_WIDTH(DATA_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // list shadow
  logic signed [DATA_W-1:0] val_mem [POOL_ENTRIES];
  logic [IDX_W-1:0]         prv_mem [POOL_ENTRIES];
  logic [IDX_W-1:0]         nxt_mem [POOL_ENTRIES];
  bit                       live_mem [POOL_ENTRIES];
  logic [IDX_W-1:0]         list_head;
  logic [IDX_W-1:0]         list_tail;
  logic                     list_is_empty;
  int                       next_slot;
  int                       live_slots [$];
  int                       gone_slots [$];

  adll_out_t   pending_answers [$];
  adll_out_t   oldest_answer;
  script_row_t script_q [$];
  int          n_mismatch;
  int          cycle_count;
  int          burst_left;
  int          stall_mode;
  int          stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [IDX_W-1:0] take_slot(logic signed [DATA_W-1:0] v);
    logic [IDX_W-1:0] n;
    n = next_slot[IDX_W-1:0];
    next_slot++;
    val_mem[n] = v;
    live_mem[n] = 1'b1;
    live_slots.push_back(n);
    return n;
  endfunction

  function automatic adll_out_t apply_list_cmd(adll_in_t c);
    adll_out_t        r;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] n;
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] q;
    bit               full;
    bit               alive;
    r = '0;
    k = c.entry_index;
    full = (next_slot >= POOL_ENTRIES);
    alive = (k != '0) && live_mem[k];
    case (c.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          r.status = STAT_FULL;
        end else begin
          n = take_slot(c.new_value);
          r.assigned_index = n;
          if (list_is_empty) begin
            prv_mem[n] = n;
            nxt_mem[n] = n;
            list_head = n;
            list_tail = n;
            list_is_empty = 1'b0;
          end else begin
            prv_mem[n] = list_tail;
            nxt_mem[n] = list_head;
            nxt_mem[list_tail] = n;
            prv_mem[list_head] = n;
            if (c.cmd == CMD_PUSH_FRONT) list_head = n;
            else list_tail = n;
          end
        end
      end
      CMD_DELETE: begin
        if (!alive) begin
          r.status = STAT_DEAD;
        end else begin
          p = prv_mem[k];
          q = nxt_mem[k];
          live_mem[k] = 1'b0;
          for (int i = 0; i < live_slots.size(); i++) begin
            if (live_slots[i] == k) begin
              live_slots.delete(i);
              break;
            end
          end
          gone_slots.push_back(k);
          if (p == k && q == k) begin
            list_head = '0;
            list_tail = '0;
            list_is_empty = 1'b1;
          end else begin
            nxt_mem[p] = q;
            prv_mem[q] = p;
            if (k == list_head) list_head = q;
            if (k == list_tail) list_tail = p;
          end
        end
      end
      CMD_INS_BEFORE, CMD_INS_AFTER: begin
        if (!alive) begin
          r.status = STAT_DEAD;
        end else if (full) begin
          r.status = STAT_FULL;
        end else begin
          n = take_slot(c.new_value);
          r.assigned_index = n;
          if (c.cmd == CMD_INS_BEFORE) begin
            p = prv_mem[k];
            nxt_mem[p] = n;
            prv_mem[n] = p;
            nxt_mem[n] = k;
            prv_mem[k] = n;
            if (list_head == k) list_head = n;
          end else begin
            q = nxt_mem[k];
            prv_mem[q] = n;
            nxt_mem[n] = q;
            prv_mem[n] = k;
            nxt_mem[k] = n;
            if (list_tail == k) list_tail = n;
          end
        end
      end
      CMD_READ: begin
        if (!alive) begin
          r.status = STAT_DEAD;
        end else begin
          r.entry_value = val_mem[k];
          r.entry_prev = prv_mem[k];
          r.entry_next = nxt_mem[k];
        end
      end
      default: begin
      end
    endcase
    r.head_index = list_head;
    r.tail_index = list_tail;
    r.list_empty = list_is_empty;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_target();
    int r;
    r = $urandom_range(99);
    if (r < 75 && live_slots.size() > 0)
      return IDX_W'(live_slots[$urandom_range(live_slots.size() - 1)]);
    if (r < 85 && gone_slots.size() > 0)
      return IDX_W'(gone_slots[$urandom_range(gone_slots.size() - 1)]);
    return IDX_W'($urandom_range(POOL_ENTRIES - 1));
  endfunction

  function automatic adll_out_t answer(logic [1:0] st, logic [IDX_W-1:0] asg,
                                       logic [IDX_W-1:0] hd, logic [IDX_W-1:0] tl,
                                       logic emp, logic [DATA_W-1:0] v,
                                       logic [IDX_W-1:0] p, logic [IDX_W-1:0] n);
    adll_out_t r;
    r.status = st;
    r.assigned_index = asg;
    r.head_index = hd;
    r.tail_index = tl;
    r.list_empty = emp;
    r.entry_value = v;
    r.entry_prev = p;
    r.entry_next = n;
    return r;
  endfunction

  task automatic add_row(input logic [2:0] c, input logic [IDX_W-1:0] k,
                         input logic [DATA_W-1:0] v, input logic typed, input adll_out_t want);
    script_row_t row;
    row.item.cmd = c;
    row.item.entry_index = k;
    row.item.new_value = v;
    row.typed = typed;
    row.want = want;
    script_q.push_back(row);
  endtask

  task automatic report_mismatch(input string msg);
    if (n_mismatch < 100) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    n_mismatch++;
  endtask

  // hold the transaction until accepted; record its answer at the accepting edge
  task automatic deliver(input adll_in_t item, input adll_out_t want);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(9) < 8 ? $urandom_range(1, 6) : $urandom_range(10, 30))
        @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_data <= item;
    in_valid <= 1'b1;
    burst_left--;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_answers.push_back(want);
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(2);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(1) == 1);
      default: out_stall <= ($urandom_range(9) < 8);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with no command outstanding");
      end else begin
        oldest_answer = pending_answers.pop_front();
        if (out_data.status !== oldest_answer.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data.status, oldest_answer.status));
        if (out_data.assigned_index !== oldest_answer.assigned_index)
          report_mismatch($sformatf("assigned_index got %0d want %0d",
                                    out_data.assigned_index, oldest_answer.assigned_index));
        if (out_data.head_index !== oldest_answer.head_index)
          report_mismatch($sformatf("head_index got %0d want %0d",
                                    out_data.head_index, oldest_answer.head_index));
        if (out_data.tail_index !== oldest_answer.tail_index)
          report_mismatch($sformatf("tail_index got %0d want %0d",
                                    out_data.tail_index, oldest_answer.tail_index));
        if (out_data.list_empty !== oldest_answer.list_empty)
          report_mismatch($sformatf("list_empty got %0d want %0d",
                                    out_data.list_empty, oldest_answer.list_empty));
        if (out_data.entry_value !== oldest_answer.entry_value)
          report_mismatch($sformatf("entry_value got %h want %h",
                                    out_data.entry_value, oldest_answer.entry_value));
        if (out_data.entry_prev !== oldest_answer.entry_prev)
          report_mismatch($sformatf("entry_prev got %0d want %0d",
                                    out_data.entry_prev, oldest_answer.entry_prev));
        if (out_data.entry_next !== oldest_answer.entry_next)
          report_mismatch($sformatf("entry_next got %0d want %0d",
                                    out_data.entry_next, oldest_answer.entry_next));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    adll_in_t  item;
    adll_out_t predicted;
    int        n_cmds;
    int        n_full;
    int        mode_left;
    bit        grow;
    int        r;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    n_mismatch = 0;
    cycle_count = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_left = 0;
    list_head = '0;
    list_tail = '0;
    list_is_empty = 1'b1;
    next_slot = 1;
    foreach (live_mem[i]) live_mem[i] = 1'b0;
    n_cmds = 0;
    n_full = 0;
    mode_left = 0;
    grow = 1'b1;

    add_row(CMD_READ, 10'd0, 32'h0, 1'b1, answer(STAT_DEAD, 0, 0, 0, 1'b1, 0, 0, 0));
    add_row(CMD_DELETE, 10'd1, 32'h0, 1'b1, answer(STAT_DEAD, 0, 0, 0, 1'b1, 0, 0, 0));
    add_row(CMD_INS_BEFORE, 10'd5, 32'h1234, 1'b1,
            answer(STAT_DEAD, 0, 0, 0, 1'b1, 0, 0, 0));
    add_row(CMD_PUSH_FRONT, 10'd1023, 32'h7fffffff, 1'b1,
            answer(STAT_OK, 1, 1, 1, 1'b0, 0, 0, 0));
    add_row(CMD_READ, 10'd1, 32'hffffffff, 1'b1,
            answer(STAT_OK, 0, 1, 1, 1'b0, 32'h7fffffff, 1, 1));
    add_row(CMD_PUSH_BACK, 10'd0, 32'h80000000, 1'b1,
            answer(STAT_OK, 2, 1, 2, 1'b0, 0, 0, 0));
    add_row(CMD_INS_BEFORE, 10'd1, 32'hffffffff, 1'b1,
            answer(STAT_OK, 3, 3, 2, 1'b0, 0, 0, 0));
    add_row(CMD_INS_AFTER, 10'd2, 32'h0, 1'b1, answer(STAT_OK, 4, 3, 4, 1'b0, 0, 0, 0));
    add_row(CMD_READ, 10'd3, 32'h0, 1'b0, '0);
    add_row(CMD_READ, 10'd4, 32'h0, 1'b0, '0);
    add_row(CMD_READ, 10'd2, 32'h0, 1'b0, '0);
    add_row(CMD_DELETE, 10'd3, 32'h0, 1'b0, '0);
    add_row(CMD_DELETE, 10'd4, 32'h0, 1'b0, '0);
    add_row(CMD_SPARE_A, 10'd1023, 32'hdeadbeef, 1'b0, '0);
    add_row(CMD_SPARE_B, 10'd512, 32'h0, 1'b0, '0);
    add_row(CMD_READ, 10'd1023, 32'h0, 1'b0, '0);
    add_row(CMD_READ, 10'd3, 32'h0, 1'b0, '0);
    add_row(CMD_INS_AFTER, 10'd3, 32'h1, 1'b0, '0);
    add_row(CMD_DELETE, 10'd1, 32'h0, 1'b0, '0);
    add_row(CMD_DELETE, 10'd2, 32'h0, 1'b0, '0);
    add_row(CMD_READ, 10'd2, 32'h0, 1'b0, '0);
    add_row(CMD_PUSH_BACK, 10'd682, 32'h55555555, 1'b0, '0);
    add_row(CMD_INS_AFTER, 10'd5, 32'haaaaaaaa, 1'b0, '0);
    add_row(CMD_READ, 10'd5, 32'h0, 1'b0, '0);
    add_row(CMD_READ, 10'd6, 32'h0, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script_q[i]) begin
      predicted = apply_list_cmd(script_q[i].item);
      deliver(script_q[i].item, script_q[i].typed ? script_q[i].want : predicted);
    end

    while ((n_cmds < RANDOM_CMDS || n_full < 20) && n_cmds < 3 * RANDOM_CMDS) begin
      if (mode_left == 0) begin
        grow = ($urandom_range(9) < 7);
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      r = $urandom_range(99);
      if (grow) begin
        item.cmd = (r < 15) ? CMD_PUSH_FRONT : (r < 30) ? CMD_PUSH_BACK :
                   (r < 47) ? CMD_INS_BEFORE : (r < 65) ? CMD_INS_AFTER :
                   (r < 75) ? CMD_DELETE : (r < 95) ? CMD_READ : CMD_SPARE_A;
      end else begin
        item.cmd = (r < 3) ? CMD_PUSH_FRONT : (r < 6) ? CMD_PUSH_BACK :
                   (r < 10) ? CMD_INS_BEFORE : (r < 14) ? CMD_INS_AFTER :
                   (r < 70) ? CMD_DELETE : (r < 95) ? CMD_READ : CMD_SPARE_A;
      end
      if (item.cmd == CMD_SPARE_A && $urandom_range(1) == 1) item.cmd = CMD_SPARE_B;
      if (item.cmd == CMD_PUSH_FRONT || item.cmd == CMD_PUSH_BACK ||
          item.cmd == CMD_SPARE_A || item.cmd == CMD_SPARE_B)
        item.entry_index = IDX_W'($urandom_range(POOL_ENTRIES - 1));
      else
        item.entry_index = pick_target();
      item.new_value = $urandom();
      predicted = apply_list_cmd(item);
      if (predicted.status == STAT_FULL) n_full++;
      if (item.cmd != CMD_SPARE_A && item.cmd != CMD_SPARE_B) n_cmds++;
      deliver(item, predicted);
    end
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== array_doubly_linked_list_unit.f =====
rtl/core/adll_pkg.sv
rtl/core/adll_store.sv
rtl/core/adll_ctrl.sv
rtl/core/array_doubly_linked_list_unit.sv
rtl/core/adll_checker.sv
tb/tb.sv
